[rtl/hcbd_pkg.sv]
// shared types, codes and helpers for the chunked body decoder
`timescale 1ns / 1ps

package hcbd_pkg;

	localparam int SIZE_BITS = 31;
	localparam logic [7:0] MAX_LINE_RESET = 8'd199;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [2:0] {
		PH_SIZE = 3'd0,
		PH_DATA = 3'd1,
		PH_CRLF = 3'd2,
		PH_TRAILER = 3'd3,
		PH_DONE = 3'd4,
		PH_ERROR = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2,
		KIND_ERR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_BAD_SIZE = 3'd1,
		ERR_OVERFLOW = 3'd2,
		ERR_LINE_LONG = 3'd3,
		ERR_NO_CRLF = 3'd4,
		ERR_TRUNCATED = 3'd5
	} err_code_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h41 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

[rtl/http_chunked_body_decoder.sv]
// chunked body decoder: input register, one-pass framing logic, result register
//
// Takes one body byte per cycle unless the input stalls and gives exactly one result
// word per byte: each byte waits in the input register, then the framing logic loads
// its word into the result register once the result side does not stall, updating
// the framing state (phase, chunk count and line fields) at the same time. When the
// result side stalls, one further word is held in the input register, then the
// input stalls. max_line_length is written through cfg_we / cfg_wdata, by the user
// only while the decoder is idle (the block does not enforce this); it resets to 199.
`timescale 1ns / 1ps

module http_chunked_body_decoder
	import hcbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,

	input  logic       item_valid,
	output logic       item_stall,
	input  logic       start_req,
	input  logic [7:0] body_byte,
	input  logic       stream_end,

	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [2:0] error_code
);

	// configuration
	logic [7:0] max_len_q;

	// input register
	logic       valid_s1;
	logic       start_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// result register
	logic       valid_s2;
	kind_t      kind_s2;
	logic [7:0] payload_s2;
	err_code_t  code_s2;

	// decoder state
	phase_t                 phase_q;
	logic [SIZE_BITS-1:0]   remaining_q;
	logic                   digit_q;
	logic                   ext_q;
	logic [7:0]             len_q;
	err_code_t              err_q;

	logic advance;
	logic load;

	phase_t               eff_phase, phase_n;
	logic [SIZE_BITS-1:0] eff_rem, rem_n;
	logic                 eff_digit, digit_n;
	logic                 eff_ext, ext_n;
	logic [7:0]           eff_len, len_n;
	err_code_t            eff_err, err_n;
	err_code_t            fail_code;
	kind_t                kind_d;
	logic [7:0]           payload_d;
	err_code_t            code_d;
	hex_t                 hex;
	logic                 is_cr, is_lf, is_sep, len_full;

	assign advance = !valid_s2 || !result_stall;
	assign load = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LINE_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			start_s1 <= start_req;
			byte_s1 <= body_byte;
			end_s1 <= stream_end;
		end
	end

	always_comb begin
		// a start request clears the decoder before this word
		eff_phase = start_s1 ? PH_SIZE : phase_q;
		eff_rem = start_s1 ? '0 : remaining_q;
		eff_digit = start_s1 ? 1'b0 : digit_q;
		eff_ext = start_s1 ? 1'b0 : ext_q;
		eff_len = start_s1 ? 8'd0 : len_q;
		eff_err = start_s1 ? ERR_NONE : err_q;

		is_cr = (byte_s1 == CH_CR);
		is_lf = (byte_s1 == CH_LF);
		is_sep = (byte_s1 == CH_SEMI) || (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);
		hex = hex_decode(byte_s1);
		len_full = (eff_len >= max_len_q);

		phase_n = eff_phase;
		rem_n = eff_rem;
		digit_n = eff_digit;
		ext_n = eff_ext;
		len_n = eff_len;
		err_n = eff_err;
		fail_code = ERR_NONE;
		kind_d = KIND_FRAME;
		payload_d = 8'd0;
		code_d = ERR_NONE;

		if (eff_phase == PH_ERROR) begin
			kind_d = KIND_ERR;
			code_d = eff_err;
		end else if (eff_phase == PH_DONE) begin
			kind_d = KIND_DONE;
		end else if (end_s1) begin
			fail_code = ERR_TRUNCATED;
		end else begin
			unique case (eff_phase)
				PH_SIZE: begin
					if (is_cr) begin
						// carriage returns are dropped
					end else if (is_lf) begin
						if (!eff_digit) begin
							fail_code = ERR_BAD_SIZE;
						end else begin
							phase_n = (eff_rem == '0) ? PH_TRAILER : PH_DATA;
							digit_n = 1'b0;
							ext_n = 1'b0;
							len_n = 8'd0;
						end
					end else if (len_full) begin
						fail_code = ERR_LINE_LONG;
					end else begin
						len_n = eff_len + 8'd1;
						if (eff_ext) begin
							// extension text is ignored
						end else if (hex.ok) begin
							if (eff_rem[SIZE_BITS-1:SIZE_BITS-4] != 4'd0) begin
								fail_code = ERR_OVERFLOW;
							end else begin
								rem_n = {eff_rem[SIZE_BITS-5:0], hex.value};
								digit_n = 1'b1;
							end
						end else if (eff_digit && is_sep) begin
							ext_n = 1'b1;
						end else begin
							fail_code = ERR_BAD_SIZE;
						end
					end
				end
				PH_DATA: begin
					kind_d = KIND_DATA;
					payload_d = byte_s1;
					if (eff_rem != '0) begin
						rem_n = eff_rem - SIZE_BITS'(1);
					end
					if (eff_rem <= SIZE_BITS'(1)) begin
						phase_n = PH_CRLF;
					end
				end
				PH_CRLF: begin
					if (is_cr) begin
					end else if (is_lf) begin
						phase_n = PH_SIZE;
						rem_n = '0;
						digit_n = 1'b0;
						ext_n = 1'b0;
						len_n = 8'd0;
					end else begin
						fail_code = ERR_NO_CRLF;
					end
				end
				PH_TRAILER: begin
					if (is_cr) begin
					end else if (is_lf) begin
						if (eff_len == 8'd0) begin
							phase_n = PH_DONE;
							kind_d = KIND_DONE;
						end else begin
							digit_n = 1'b0;
							ext_n = 1'b0;
							len_n = 8'd0;
						end
					end else if (len_full) begin
						fail_code = ERR_LINE_LONG;
					end else begin
						len_n = eff_len + 8'd1;
					end
				end
				default: begin
				end
			endcase
		end

		if (fail_code != ERR_NONE) begin
			phase_n = PH_ERROR;
			err_n = fail_code;
			kind_d = KIND_ERR;
			payload_d = 8'd0;
			code_d = fail_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			remaining_q <= '0;
			digit_q <= 1'b0;
			ext_q <= 1'b0;
			len_q <= 8'd0;
			err_q <= ERR_NONE;
		end else if (load) begin
			phase_q <= phase_n;
			remaining_q <= rem_n;
			digit_q <= digit_n;
			ext_q <= ext_n;
			len_q <= len_n;
			err_q <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s2 <= kind_d;
			payload_s2 <= payload_d;
			code_s2 <= code_d;
		end
	end

	assign result_valid = valid_s2;
	assign kind = kind_s2;
	assign payload_byte = payload_s2;
	assign error_code = code_s2;

	// an error word always leaves the decoder in the sticky error phase
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(load && kind_d == KIND_ERR) |=> (phase_q == PH_ERROR && err_q != ERR_NONE))
		else $error("error word without sticky error state");

	// error code is set exactly on error words
	a_code_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((kind == KIND_ERR) == (error_code != ERR_NONE)))
		else $error("error code does not match kind");

	// only payload words carry a byte
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != KIND_DATA) |-> (payload_byte == 8'd0))
		else $error("non-payload word carries a byte");

	// input stalls only while a word waits behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a held result");

endmodule
